FILE: src/lfed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfed_pkg: shared types and constants of the length framed deframer
// Byte codes, the front-to-back command word and the store depth default.
// ----------------------------------------------------------------------------
package lfed_pkg;

    localparam int PAYLOAD_DEPTH_DEFAULT = 64;

    localparam logic [7:0] BYTE_START = 8'hFF;
    localparam logic [7:0] BYTE_END   = 8'hFE;
    localparam logic [7:0] BYTE_ESC   = 8'hFD;
    localparam logic [7:0] ESC_OFFSET = 8'hF0;

    typedef enum logic {
        CMD_STORE   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_op_t;

    // One command from the front to the back: store a byte or release a frame.
    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic [5:0] idx;
        logic [6:0] len;
    } cmd_t;

endpackage : lfed_pkg
`default_nettype wire

FILE: src/lfed_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfed_rx_if / lfed_res_if: ready/valid channels of the deframer
// The received byte channel and the result channel.
// ----------------------------------------------------------------------------
interface lfed_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface : lfed_rx_if

interface lfed_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [6:0] frame_length;
    logic       last_flag;

    modport source (output valid, output payload_byte, output byte_index,
                    output frame_length, output last_flag, input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input frame_length, input last_flag, output ready);
endinterface : lfed_res_if
`default_nettype wire

FILE: src/lfed_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfed_front: frame parser
// Tracks start, length, escapes and closing byte; issues store and release
// commands to the back end.
// ----------------------------------------------------------------------------
module lfed_front #(
    parameter int PAYLOAD_DEPTH = lfed_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lfed_rx_if.sink            rx,
    output lfed_pkg::cmd_t     push_cmd,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import lfed_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_LENGTH = 3'b010,
        F_BODY   = 3'b100
    } front_state_t;

    front_state_t phase_reg, phase_next;
    logic         esc_reg, esc_next;
    logic [7:0]   remaining_reg, remaining_next;
    logic [6:0]   windex_reg, windex_next;
    logic         too_long_reg, too_long_next;

    logic         accept;
    logic [7:0]   value;
    logic         gen;
    cmd_t         cmd;

    assign rx.ready = push_ready;
    assign accept   = rx.valid && push_ready;
    assign value    = esc_reg ? (rx.rx_byte + ESC_OFFSET) : rx.rx_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        esc_next       = esc_reg;
        remaining_next = remaining_reg;
        windex_next    = windex_reg;
        too_long_next  = too_long_reg;
        gen            = 1'b0;
        cmd.op         = CMD_STORE;
        cmd.data       = value;
        cmd.idx        = windex_reg[5:0];
        cmd.len        = windex_reg;
        unique case (phase_reg)
            F_LENGTH:
            begin
                remaining_next = rx.rx_byte;
                too_long_next  = rx.rx_byte > 8'(PAYLOAD_DEPTH);
                phase_next     = F_BODY;
            end
            F_BODY:
            begin
                if (rx.rx_byte == BYTE_ESC)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next = 1'b0;
                    if (remaining_reg != 8'd0)
                    begin
                        if (!too_long_reg && windex_reg < 7'(PAYLOAD_DEPTH))
                        begin
                            gen         = 1'b1;
                            windex_next = windex_reg + 7'd1;
                        end
                        remaining_next = remaining_reg - 8'd1;
                    end
                    else
                    begin
                        // closing byte: release only a good frame
                        if (value == BYTE_END && !too_long_reg)
                        begin
                            gen    = 1'b1;
                            cmd.op = CMD_RELEASE;
                        end
                        phase_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = F_IDLE;
                if (rx.rx_byte == BYTE_START)
                begin
                    phase_next     = F_LENGTH;
                    windex_next    = 7'd0;
                    esc_next       = 1'b0;
                    remaining_next = 8'd0;
                    too_long_next  = 1'b0;
                end
            end
        endcase
    end

    assign push_cmd   = cmd;
    assign push_valid = accept && gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= F_IDLE;
            esc_reg       <= 1'b0;
            remaining_reg <= 8'd0;
            windex_reg    <= 7'd0;
            too_long_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            esc_reg       <= esc_next;
            remaining_reg <= remaining_next;
            windex_reg    <= windex_next;
            too_long_reg  <= too_long_next;
        end
    end

`ifndef SYNTHESIS
    a_windex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        windex_reg <= 7'(PAYLOAD_DEPTH))
        else $error("write index beyond store depth");
    a_store_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (phase_reg == F_BODY))
        else $error("command issued outside frame body");
    a_short_frame_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == F_BODY && !too_long_reg)
            |-> ({1'b0, windex_reg} + {1'b0, remaining_reg}) <= 9'(PAYLOAD_DEPTH))
        else $error("frame would overflow store");
`endif
endmodule : lfed_front
`default_nettype wire

FILE: src/lfed_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfed_queue: two-entry command queue
// Decouples the parser from the store and drain engine.
// ----------------------------------------------------------------------------
module lfed_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lfed_pkg::cmd_t push_cmd,
    input  wire logic           push_valid,
    output logic                push_ready,
    output lfed_pkg::cmd_t      pop_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready
);
    import lfed_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count overflow");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop_ready) |=> (count_reg == 2'd2))
        else $error("full queue lost an entry");
`endif
endmodule : lfed_queue
`default_nettype wire

FILE: src/lfed_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfed_back: payload store and drain engine
// Writes stored bytes into the payload memory and drains released frames.
// ----------------------------------------------------------------------------
module lfed_back #(
    parameter int PAYLOAD_DEPTH = lfed_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lfed_pkg::cmd_t pop_cmd,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    lfed_res_if.source          res
);
    import lfed_pkg::*;

    localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_OUT  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [5:0]  k_reg, k_next;
    logic [6:0]  len_reg, len_next;
    logic        empty_reg, empty_next;
    logic [7:0]  rd_data_reg;
    logic [7:0]  mem [PAYLOAD_DEPTH];
    logic        last;
    logic        do_pop;
    logic        do_write;

    assign pop_ready = state_reg == B_IDLE;
    assign do_pop    = pop_valid && pop_ready;
    assign do_write  = do_pop && pop_cmd.op == CMD_STORE;
    assign last      = empty_reg || (({1'b0, k_reg} + 7'd1) == len_reg);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[pop_cmd.idx[IDX_W-1:0]] <= pop_cmd.data;
        end
        rd_data_reg <= mem[k_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        len_next   = len_reg;
        empty_next = empty_reg;
        unique case (state_reg)
            B_READ:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (res.ready)
                begin
                    if (last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                if (do_pop && pop_cmd.op == CMD_RELEASE)
                begin
                    k_next     = 6'd0;
                    len_next   = pop_cmd.len;
                    empty_next = pop_cmd.len == 7'd0;
                    state_next = (pop_cmd.len == 7'd0) ? B_OUT : B_READ;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            k_reg     <= 6'd0;
            len_reg   <= 7'd0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            len_reg   <= len_next;
            empty_reg <= empty_next;
        end
    end

    assign res.valid        = state_reg == B_OUT;
    assign res.payload_byte = empty_reg ? 8'd0 : rd_data_reg;
    assign res.byte_index   = k_reg;
    assign res.frame_length = len_reg;
    assign res.last_flag    = last;

`ifndef SYNTHESIS
    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && !empty_reg) |-> ({1'b0, k_reg} < len_reg))
        else $error("drain index beyond frame length");
    a_stall_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && !res.ready) |=> (state_reg == B_OUT && $stable(k_reg)))
        else $error("drain advanced during stall");
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && res.ready && last) |=> (state_reg == B_IDLE))
        else $error("drain did not finish after last beat");
`endif
endmodule : lfed_back
`default_nettype wire

FILE: src/length_framed_escape_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_framed_escape_deframer: length prefixed, byte stuffed frame receiver
// Parses 0xFF / length / payload / 0xFE frames with 0xFD escapes and emits
// the payload of each good frame as a run of beats with a last mark.
// ----------------------------------------------------------------------------
// Input: one byte beat per cycle while the command queue has room; payload
//   bytes are written to the store one per cycle by the back end while idle.
// Drain: the back end takes a release command only while idle; each beat
//   then passes a memory read state (B_READ) and an output state (B_OUT),
//   set by the registered store read; an empty frame skips B_READ.
// Reset: parser, queue and drain engine return to idle at once; the payload
//   store holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module length_framed_escape_deframer #(
    parameter int PAYLOAD_DEPTH = lfed_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lfed_rx_if.sink     rx,
    lfed_res_if.source  res
);
    import lfed_pkg::*;

    // front -> queue
    cmd_t push_cmd;
    logic push_valid;
    logic push_ready;

    // queue -> back
    cmd_t pop_cmd;
    logic pop_valid;
    logic pop_ready;

    // Parse the byte stream; hold rx while the queue is full.
    lfed_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Buffer up to two commands so parsing can go on while a frame drains.
    lfed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Store payload bytes and drain released frames in command order, so a
    // new frame's bytes never overwrite a frame that is still draining.
    lfed_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .res       (res)
    );

endmodule : length_framed_escape_deframer
`default_nettype wire

FILE: bench/tb_length_framed_escape_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_framed_escape_deframer: self-checking bench of the frame receiver
// Feeds byte beats (directed table, then random well-formed, broken, overlong
// and noise frames), predicts every payload beat in the bench and checks each
// result beat in order, with random idling on both channels and one long
// result stall that backs the receiver up into its byte input.
// ----------------------------------------------------------------------------
module tb_length_framed_escape_deframer;

    import lfed_pkg::*;

    localparam int DEPTH        = PAYLOAD_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;

    // One result beat as the bench expects it.
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] idx;
        logic [6:0] len;
        logic       last;
    } beat_t;

    // One directed byte; typed rows carry the single beat they must release.
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        beat_t      res;
    } row_t;

    // Parser phases of the bench's own receiver copy.
    typedef enum logic [1:0] {
        HUNT    = 2'd0,
        GET_LEN = 2'd1,
        COLLECT = 2'd2
    } rx_phase_t;

    localparam beat_t NO_BEAT = '0;

    localparam row_t DIRECTED_ROWS [24] = '{
        // empty frame: one beat of zeros with the last mark
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'hFE, 1'b1, '{8'h00, 6'd0, 7'd0, 1'b1}},
        // single zero byte
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h01, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'hFE, 1'b1, '{8'h00, 6'd0, 7'd1, 1'b1}},
        // escaped byte wraps to the top value
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h01, 1'b0, NO_BEAT},
        '{8'hFD, 1'b0, NO_BEAT},
        '{8'h0F, 1'b0, NO_BEAT},
        '{8'hFE, 1'b1, '{8'hFF, 6'd0, 7'd1, 1'b1}},
        // start byte as data, double escape, escaped closing byte
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h02, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'hFD, 1'b0, NO_BEAT},
        '{8'hFD, 1'b0, NO_BEAT},
        '{8'h0E, 1'b0, NO_BEAT},
        '{8'hFD, 1'b0, NO_BEAT},
        '{8'h0E, 1'b0, NO_BEAT},
        // wrong closing byte drops the frame
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h12, 1'b0, NO_BEAT},
        // escape byte while hunting is ignored
        '{8'hFD, 1'b0, NO_BEAT}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lfed_rx_if  rx_ch ();
    lfed_res_if res_ch ();

    length_framed_escape_deframer #(
        .PAYLOAD_DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bench copy of the receiver state.
    rx_phase_t  prs_phase  = HUNT;
    bit         esc_armed  = 1'b0;
    logic [7:0] remaining  = 8'd0;
    int         stored     = 0;
    bit         overlong   = 1'b0;
    logic [7:0] payload_copy [DEPTH];

    beat_t expected_beats [$];

    int  error_count     = 0;
    int  cycle_count     = 0;
    int  items_sent      = 0;
    int  noise_sent      = 0;
    int  beats_checked   = 0;
    int  frames_released = 0;
    int  overlong_frames = 0;
    int  bad_frames      = 0;
    bit  hold_armed      = 1'b0;
    bit  src_steady      = 1'b0;
    bit  sink_steady     = 1'b0;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Advance the bench receiver by one byte and append the beats it releases.
    function automatic void deframe_byte(input logic [7:0] rx_b, ref beat_t beats [$]);
        logic [7:0] ch;
        int         k;
        beat_t      bt;
        ch = rx_b;
        case (prs_phase)
            GET_LEN:
            begin
                remaining = ch;
                overlong  = (ch > DEPTH);
                prs_phase = COLLECT;
            end
            COLLECT:
            begin
                if (ch == BYTE_ESC)
                begin
                    // a repeated escape keeps the escape pending
                    esc_armed = 1'b1;
                end
                else
                begin
                    if (esc_armed)
                    begin
                        ch        = ch + ESC_OFFSET;
                        esc_armed = 1'b0;
                    end
                    if (remaining != 8'd0)
                    begin
                        if (!overlong && stored < DEPTH)
                        begin
                            payload_copy[stored] = ch;
                            stored++;
                        end
                        remaining = remaining - 8'd1;
                    end
                    else
                    begin
                        // closing byte: release only a good, stored frame
                        if (ch == BYTE_END && !overlong)
                        begin
                            if (stored == 0)
                            begin
                                beats.push_back('{8'h00, 6'd0, 7'd0, 1'b1});
                            end
                            for (k = 0; k < stored; k++)
                            begin
                                bt.data = payload_copy[k];
                                bt.idx  = k[5:0];
                                bt.len  = stored[6:0];
                                bt.last = (k + 1 == stored);
                                beats.push_back(bt);
                            end
                        end
                        prs_phase = HUNT;
                    end
                end
            end
            default:
            begin
                prs_phase = HUNT;
                if (ch == BYTE_START)
                begin
                    prs_phase = GET_LEN;
                    stored    = 0;
                    esc_armed = 1'b0;
                    remaining = 8'd0;
                    overlong  = 1'b0;
                end
            end
        endcase
    endfunction

    // Offer one byte beat after a random gap; call at a falling edge, return at one.
    task automatic send_byte(input logic [7:0] b, input logic typed, input beat_t typed_beat);
        int    gap;
        beat_t fresh [$];
        gap = src_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1) @(posedge clk);
        deframe_byte(b, fresh);
        if (typed)
        begin
            if (fresh.size() != 1 || fresh[0] != typed_beat)
            begin
                report_mismatch($sformatf("table row for byte %02h disagrees with predictor", b));
            end
            expected_beats.push_back(typed_beat);
        end
        else
        begin
            foreach (fresh[i]) expected_beats.push_back(fresh[i]);
        end
        @(negedge clk);
    endtask

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random ready gaps, one long hold, in-order beat check.
    initial
    begin : result_sink
        int    gap;
        int    held;
        beat_t got;
        beat_t want;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_armed)
            begin
                // hold off long enough for the byte input to back up
                hold_armed = 1'b0;
                res_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
            end
            else
            begin
                if ($urandom_range(0, 24) == 0) sink_steady = !sink_steady;
                gap = sink_steady ? 0 : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (res_ch.valid !== 1'b1 && !hold_armed) @(posedge clk);
            if (res_ch.valid === 1'b1)
            begin
                got.data = res_ch.payload_byte;
                got.idx  = res_ch.byte_index;
                got.len  = res_ch.frame_length;
                got.last = res_ch.last_flag;
                if (expected_beats.size() == 0)
                begin
                    report_mismatch($sformatf("beat %02h idx %0d len %0d last %0b with no frame due",
                                              got.data, got.idx, got.len, got.last));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.data !== want.data || got.idx !== want.idx ||
                        got.len !== want.len || got.last !== want.last)
                    begin
                        report_mismatch($sformatf(
                            "got data %02h idx %0d len %0d last %0b, want %02h %0d %0d %0b",
                            got.data, got.idx, got.len, got.last,
                            want.data, want.idx, want.len, want.last));
                    end
                end
                beats_checked++;
                if (got.last === 1'b1) frames_released++;
            end
            @(negedge clk);
        end
    end

    // Byte side: reset, directed table, then random frames.
    initial
    begin : byte_source
        logic [7:0] frame_q [$];
        logic [7:0] len;
        logic [7:0] b;
        int         kind;
        int         n;
        bit         first;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
            items_sent++;
        end

        first = 1'b1;
        while (items_sent < RANDOM_ITEMS + $size(DIRECTED_ROWS))
        begin
            frame_q.delete();
            if ($urandom_range(0, 5) == 0) src_steady = !src_steady;
            kind = first ? 99 : $urandom_range(0, 99);
            if (kind < 8)
            begin
                // idle noise: anything but a start byte is ignored
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == BYTE_START) b = 8'h00;
                    send_byte(b, 1'b0, NO_BEAT);
                    noise_sent++;
                end
            end
            else
            begin
                if (first)
                begin
                    // full-depth frame while the result side holds off
                    len        = 8'(DEPTH);
                    hold_armed = 1'b1;
                end
                else if (kind < 12)
                begin
                    len = 8'($urandom_range(DEPTH + 1, DEPTH + 16));
                    overlong_frames++;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    len = 8'($urandom_range(DEPTH - 8, DEPTH));
                end
                else
                begin
                    len = 8'($urandom_range(0, 10));
                end
                frame_q.push_back(BYTE_START);
                frame_q.push_back(len);
                repeat (len)
                begin
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 7) == 0)
                    begin
                        case ($urandom_range(0, 3))
                            0: b = BYTE_START;
                            1: b = BYTE_END;
                            2: b = BYTE_ESC;
                            default: b = 8'h00;
                        endcase
                    end
                    // escape the escape byte always, others now and then;
                    // skip bytes whose escaped form would itself be an escape
                    if (b == BYTE_ESC || (b != 8'hED && $urandom_range(0, 5) == 0))
                    begin
                        frame_q.push_back(BYTE_ESC);
                        if ($urandom_range(0, 9) == 0) frame_q.push_back(BYTE_ESC);
                        frame_q.push_back(b - ESC_OFFSET);
                    end
                    else
                    begin
                        frame_q.push_back(b);
                    end
                end
                if (kind >= 12 && kind < 20)
                begin
                    frame_q.push_back(8'($urandom_range(0, 8'hFC)));
                    bad_frames++;
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    frame_q.push_back(BYTE_ESC);
                    frame_q.push_back(BYTE_END - ESC_OFFSET);
                end
                else
                begin
                    frame_q.push_back(BYTE_END);
                end
                foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, NO_BEAT);
                items_sent += frame_q.size();
            end
            first = 1'b0;
        end
        rx_ch.valid <= 1'b0;

        // drain: wait for every predicted beat, then let stray beats show up
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d frame bytes and %0d idle noise bytes; checked %0d beats in %0d frames",
                 items_sent, noise_sent, beats_checked, frames_released);
        $display("Random frames dropped: %0d overlong, %0d bad close; one %0d-cycle result stall",
                 overlong_frames, bad_frames, HOLD_CYCLES);
        if (error_count == 0 && expected_beats.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule : tb_length_framed_escape_deframer
